// File: hdl/wss_pkg.sv
// Package for the weighted stake selector: widths, codes, state types and
// the command/response structs of the shared arithmetic unit. No dependencies.
`timescale 1ns / 1ps
package wss_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int SLOT_W         = 4;
  localparam int STAKE_W        = 56;
  localparam int REWARD_W       = 64;
  localparam int PICK_W         = 64;
  localparam int TOTAL_W        = 64;
  localparam int PROD_W         = STAKE_W + STAKE_W;
  localparam int DIVIDEND_W     = 128;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int IN_TDATA_W     = 128;
  localparam int OUT_TDATA_W    = 128;
  localparam logic [STAKE_W-1:0] STAKE_FLOOR_RST = 56'd100000000000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_STAKE_FLOOR = 3'd0;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_SELECT   = 3'd2,
    OP_VALIDATE = 3'd3,
    OP_DIST     = 3'd4,
    OP_READ     = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LOW_STAKE = 2'd1,
    ST_NO_STAKE  = 2'd2,
    ST_ABSENT    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SUM_RD,
    S_SUM_ACC,
    S_MOD,
    S_WALK_RD,
    S_WALK_CMP,
    S_DIST_RD,
    S_DIST_CHK,
    S_DIST_MD,
    S_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_MUL,
    AR_DIV
  } arith_state_t;

  typedef enum logic {
    AMODE_MOD,
    AMODE_MULDIV
  } arith_mode_t;

  typedef struct packed {
    logic        start;
    arith_mode_t mode;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_resp_t;

endpackage

// File: hdl/weighted_stake_selector_unit.sv
// Top level of the weighted stake selector: sequencer, marks, config register.
// Depends on wss_pkg, wss_ram, wss_arith.
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser opcode; tdata slot, amount, pick
// out_     out  tvalid/tready      tuser status; tdata slot, marks, stake, rewards
// cfg_     in   APB psel/penable   stake floor at byte address 0
//
// add, remove, validate, unused codes, read of an absent entry: straight to the
// result; read of a present entry: through S_READ first.
// select: sum sweep over all slots, modulo divide, walk up to the chosen entry.
// distribute: sum sweep, then a multiply and divide in the shared unit for each
// active entry and a read and check for each inactive one. in_tready is low until the
// result is taken.
// Synchronous active-low reset clears marks and control; no clearing pass.
`timescale 1ns / 1ps
module weighted_stake_selector_unit #(
  parameter int SLOTS = wss_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2:0]                          in_tuser,  // opcode
  input  logic [wss_pkg::IN_TDATA_W-1:0]      in_tdata,  // slot, amount, pick
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [1:0]                          out_tuser, // status
  output logic [wss_pkg::OUT_TDATA_W-1:0]     out_tdata, // chosen_slot, entry_present,
                                                         // entry_active, entry_stake,
                                                         // entry_rewards
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wss_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [wss_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [wss_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  wss_pkg::ctrl_state_t state_r, state_nxt;

  logic [wss_pkg::STAKE_W-1:0]  stake_floor_r;
  logic [SLOTS-1:0]             present_r, present_nxt;
  logic [SLOTS-1:0]             active_r, active_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic                         is_sel_r, is_sel_nxt;
  logic [wss_pkg::STAKE_W-1:0]  amount_r, amount_nxt;
  logic [wss_pkg::PICK_W-1:0]   pick_r, pick_nxt;
  logic [wss_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [wss_pkg::TOTAL_W-1:0]  cum_r, cum_nxt;

  logic [1:0]                   res_status_r, res_status_nxt;
  logic [wss_pkg::SLOT_W-1:0]   res_chosen_r, res_chosen_nxt;
  logic                         res_pres_r, res_pres_nxt;
  logic                         res_act_r, res_act_nxt;
  logic [wss_pkg::STAKE_W-1:0]  res_stake_r, res_stake_nxt;
  logic [wss_pkg::REWARD_W-1:0] res_rew_r, res_rew_nxt;

  logic                         in_acc;
  logic [2:0]                   in_op;
  logic [wss_pkg::SLOT_W-1:0]   in_slot;
  logic [wss_pkg::STAKE_W-1:0]  in_amount;
  logic [wss_pkg::PICK_W-1:0]   in_pick;
  logic [IDX_W+wss_pkg::SLOT_W-1:0] slot_ext;
  logic [IDX_W+wss_pkg::SLOT_W-1:0] idx_ext;
  logic [IDX_W-1:0]             in_idx;
  logic                         in_range;

  logic                         stake_we, rew_we;
  logic [IDX_W-1:0]             waddr, raddr;
  logic [wss_pkg::STAKE_W-1:0]  stake_wdata, stake_rdata;
  logic [wss_pkg::REWARD_W-1:0] rew_wdata, rew_rdata;

  wss_pkg::arith_cmd_t          ar_cmd;
  wss_pkg::arith_resp_t         ar_resp;
  logic [wss_pkg::PICK_W-1:0]   ar_a;
  logic [wss_pkg::REWARD_W-1:0] ar_quo;
  logic [wss_pkg::TOTAL_W-1:0]  ar_rem;

  logic [wss_pkg::TOTAL_W-1:0]  stake_ext;
  logic [wss_pkg::TOTAL_W-1:0]  total_sum;
  logic [wss_pkg::TOTAL_W-1:0]  cum_sum;
  logic [wss_pkg::REWARD_W:0]   rew_sum;
  logic                         cfg_wr;

  assign in_op     = in_tuser;
  assign in_slot   = in_tdata[3:0];
  assign in_amount = in_tdata[59:4];
  assign in_pick   = in_tdata[123:60];
  assign slot_ext  = {{IDX_W{1'b0}}, in_slot};
  assign in_idx    = slot_ext[IDX_W-1:0];
  assign in_range  = (slot_ext < (IDX_W+wss_pkg::SLOT_W)'(SLOTS));
  assign idx_ext   = {{wss_pkg::SLOT_W{1'b0}}, idx_r};
  assign in_acc    = in_tvalid && in_tready;

  assign stake_ext = {{(wss_pkg::TOTAL_W-wss_pkg::STAKE_W){1'b0}}, stake_rdata};
  assign total_sum = total_r + (active_r[idx_r] ? stake_ext : '0);
  assign cum_sum   = cum_r + stake_ext;
  assign rew_sum   = {1'b0, rew_rdata} + {1'b0, ar_quo};

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == wss_pkg::ADDR_STAKE_FLOOR)
                    ? {{(wss_pkg::CFG_DATA_W-wss_pkg::STAKE_W){1'b0}}, stake_floor_r}
                    : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stake_floor_r <= wss_pkg::STAKE_FLOOR_RST;
    end else if (cfg_wr && cfg_paddr == wss_pkg::ADDR_STAKE_FLOOR) begin
      stake_floor_r <= cfg_pwdata[wss_pkg::STAKE_W-1:0];
    end
  end

  // tables
  assign raddr = (state_r == wss_pkg::S_IDLE) ? in_idx : idx_r;

  wss_ram #(.WIDTH(wss_pkg::STAKE_W), .DEPTH(SLOTS)) u_stake_ram (
    .clk   (clk),
    .we    (stake_we),
    .waddr (waddr),
    .wdata (stake_wdata),
    .raddr (raddr),
    .rdata (stake_rdata)
  );

  wss_ram #(.WIDTH(wss_pkg::REWARD_W), .DEPTH(SLOTS)) u_reward_ram (
    .clk   (clk),
    .we    (rew_we),
    .waddr (waddr),
    .wdata (rew_wdata),
    .raddr (raddr),
    .rdata (rew_rdata)
  );

  assign ar_a = is_sel_r ? pick_r
              : {{(wss_pkg::PICK_W-wss_pkg::STAKE_W){1'b0}}, amount_r};

  wss_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ar_cmd),
    .op_a  (ar_a),
    .op_b  (stake_rdata),
    .op_d  (is_sel_r ? total_sum : total_r),
    .resp  (ar_resp),
    .quo   (ar_quo),
    .rem   (ar_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wss_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            wss_pkg::OP_READ: state_nxt = (in_range && present_r[in_idx])
                                          ? wss_pkg::S_READ : wss_pkg::S_OUT;
            wss_pkg::OP_SELECT,
            wss_pkg::OP_DIST:  state_nxt = wss_pkg::S_SUM_RD;
            default:           state_nxt = wss_pkg::S_OUT;
          endcase
        end
      end
      wss_pkg::S_READ:   state_nxt = wss_pkg::S_OUT;
      wss_pkg::S_SUM_RD: state_nxt = wss_pkg::S_SUM_ACC;
      wss_pkg::S_SUM_ACC: begin
        if (idx_r != IDX_LAST) begin
          state_nxt = wss_pkg::S_SUM_RD;
        end else if (total_sum == '0) begin
          state_nxt = wss_pkg::S_OUT;
        end else if (is_sel_r) begin
          state_nxt = wss_pkg::S_MOD;
        end else begin
          state_nxt = wss_pkg::S_DIST_RD;
        end
      end
      wss_pkg::S_MOD: begin
        if (ar_resp.done) begin
          state_nxt = wss_pkg::S_WALK_RD;
        end
      end
      wss_pkg::S_WALK_RD: state_nxt = wss_pkg::S_WALK_CMP;
      wss_pkg::S_WALK_CMP: begin
        if ((active_r[idx_r] && pick_r < cum_sum) || idx_r == IDX_LAST) begin
          state_nxt = wss_pkg::S_OUT;
        end else begin
          state_nxt = wss_pkg::S_WALK_RD;
        end
      end
      wss_pkg::S_DIST_RD: state_nxt = wss_pkg::S_DIST_CHK;
      wss_pkg::S_DIST_CHK: begin
        if (active_r[idx_r]) begin
          state_nxt = wss_pkg::S_DIST_MD;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = wss_pkg::S_OUT;
        end else begin
          state_nxt = wss_pkg::S_DIST_RD;
        end
      end
      wss_pkg::S_DIST_MD: begin
        if (ar_resp.done) begin
          state_nxt = (idx_r == IDX_LAST) ? wss_pkg::S_OUT : wss_pkg::S_DIST_RD;
        end
      end
      wss_pkg::S_OUT: begin
        if (out_tready) begin
          state_nxt = wss_pkg::S_IDLE;
        end
      end
      default: state_nxt = wss_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    present_nxt    = present_r;
    active_nxt     = active_r;
    idx_nxt        = idx_r;
    is_sel_nxt     = is_sel_r;
    amount_nxt     = amount_r;
    pick_nxt       = pick_r;
    total_nxt      = total_r;
    cum_nxt        = cum_r;
    res_status_nxt = res_status_r;
    res_chosen_nxt = res_chosen_r;
    res_pres_nxt   = res_pres_r;
    res_act_nxt    = res_act_r;
    res_stake_nxt  = res_stake_r;
    res_rew_nxt    = res_rew_r;
    stake_we       = 1'b0;
    rew_we         = 1'b0;
    waddr          = idx_r;
    stake_wdata    = in_amount;
    rew_wdata      = rew_sum[wss_pkg::REWARD_W] ? '1 : rew_sum[wss_pkg::REWARD_W-1:0];
    ar_cmd.start   = 1'b0;
    ar_cmd.mode    = is_sel_r ? wss_pkg::AMODE_MOD : wss_pkg::AMODE_MULDIV;
    in_tready      = (state_r == wss_pkg::S_IDLE);
    out_tvalid     = (state_r == wss_pkg::S_OUT);
    case (state_r)
      wss_pkg::S_IDLE: begin
        waddr = in_idx;
        if (in_acc) begin
          idx_nxt        = '0;
          total_nxt      = '0;
          amount_nxt     = in_amount;
          pick_nxt       = in_pick;
          is_sel_nxt     = (in_op == wss_pkg::OP_SELECT);
          res_status_nxt = wss_pkg::ST_OK;
          res_chosen_nxt = '0;
          res_pres_nxt   = 1'b0;
          res_act_nxt    = 1'b0;
          res_stake_nxt  = '0;
          res_rew_nxt    = '0;
          case (in_op)
            wss_pkg::OP_ADD: begin
              if (!in_range) begin
                res_status_nxt = wss_pkg::ST_ABSENT;
              end else if (in_amount < stake_floor_r) begin
                res_status_nxt = wss_pkg::ST_LOW_STAKE;
              end else begin
                present_nxt[in_idx] = 1'b1;
                active_nxt[in_idx]  = 1'b1;
                stake_we            = 1'b1;
                rew_we              = 1'b1;
                rew_wdata           = '0;
              end
            end
            wss_pkg::OP_REMOVE: begin
              if (!in_range || !present_r[in_idx]) begin
                res_status_nxt = wss_pkg::ST_ABSENT;
              end else begin
                active_nxt[in_idx] = 1'b0;
              end
            end
            wss_pkg::OP_VALIDATE,
            wss_pkg::OP_READ: begin
              if (!in_range || !active_r[in_idx]) begin
                res_status_nxt = wss_pkg::ST_ABSENT;
              end
              if (in_op == wss_pkg::OP_READ) begin
                idx_nxt = in_idx;
                res_status_nxt = (in_range && present_r[in_idx])
                               ? wss_pkg::ST_OK : wss_pkg::ST_ABSENT;
              end
            end
            default: ;
          endcase
        end
      end
      wss_pkg::S_READ: begin
        res_pres_nxt  = 1'b1;
        res_act_nxt   = active_r[idx_r];
        res_stake_nxt = stake_rdata;
        res_rew_nxt   = rew_rdata;
      end
      wss_pkg::S_SUM_ACC: begin
        total_nxt = total_sum;
        if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          idx_nxt = '0;
          if (total_sum == '0) begin
            res_status_nxt = wss_pkg::ST_NO_STAKE;
          end else if (is_sel_r) begin
            ar_cmd.start = 1'b1;
          end
        end
      end
      wss_pkg::S_MOD: begin
        if (ar_resp.done) begin
          pick_nxt = ar_rem;
          cum_nxt  = '0;
        end
      end
      wss_pkg::S_WALK_CMP: begin
        if (active_r[idx_r]) begin
          cum_nxt = cum_sum;
          if (pick_r < cum_sum) begin
            res_chosen_nxt = idx_ext[wss_pkg::SLOT_W-1:0];
          end
        end
        if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      wss_pkg::S_DIST_CHK: begin
        if (active_r[idx_r]) begin
          ar_cmd.start = !ar_resp.busy;
        end else if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      wss_pkg::S_DIST_MD: begin
        if (ar_resp.done) begin
          rew_we = 1'b1;
          if (idx_r != IDX_LAST) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= wss_pkg::S_IDLE;
      present_r <= '0;
      active_r  <= '0;
      idx_r     <= '0;
      is_sel_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      active_r  <= active_nxt;
      idx_r     <= idx_nxt;
      is_sel_r  <= is_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amount_r     <= amount_nxt;
    pick_r       <= pick_nxt;
    total_r      <= total_nxt;
    cum_r        <= cum_nxt;
    res_status_r <= res_status_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_pres_r   <= res_pres_nxt;
    res_act_r    <= res_act_nxt;
    res_stake_r  <= res_stake_nxt;
    res_rew_r    <= res_rew_nxt;
  end

  assign out_tuser = res_status_r;
  assign out_tdata = {2'b00, res_rew_r, res_stake_r, res_act_r, res_pres_r, res_chosen_r};

endmodule

// File: hdl/wss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module wss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/wss_arith.sv
// Shared bit-serial arithmetic unit: shift-add multiply then restoring divide;
// the modulo mode runs the divide alone. Depends on wss_pkg.
`timescale 1ns / 1ps
module wss_arith (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wss_pkg::arith_cmd_t               cmd,
  input  logic [wss_pkg::PICK_W-1:0]        op_a,
  input  logic [wss_pkg::STAKE_W-1:0]       op_b,
  input  logic [wss_pkg::TOTAL_W-1:0]       op_d,
  output wss_pkg::arith_resp_t              resp,
  output logic [wss_pkg::REWARD_W-1:0]      quo,
  output logic [wss_pkg::TOTAL_W-1:0]       rem
);

  wss_pkg::arith_state_t state_r, state_nxt;
  logic [6:0]                       cnt_r, cnt_nxt;
  logic                             done_r, done_nxt;
  logic [wss_pkg::DIVIDEND_W-1:0]   num_r, num_nxt;
  logic [wss_pkg::PROD_W-1:0]       mcand_r, mcand_nxt;
  logic [wss_pkg::STAKE_W-1:0]      mplier_r, mplier_nxt;
  logic [wss_pkg::TOTAL_W-1:0]      d_r, d_nxt;
  logic [wss_pkg::TOTAL_W-1:0]      rem_r, rem_nxt;
  logic [wss_pkg::REWARD_W-1:0]     quo_r, quo_nxt;
  logic [wss_pkg::TOTAL_W:0]        rs;
  logic [wss_pkg::TOTAL_W:0]        rdiff;
  logic                             ge;

  localparam logic [6:0] MUL_LAST = 7'(wss_pkg::STAKE_W - 1);
  localparam logic [6:0] DIV_LAST = 7'(wss_pkg::DIVIDEND_W - 1);

  assign rs    = {rem_r, num_r[wss_pkg::DIVIDEND_W-1]};
  assign rdiff = rs - {1'b0, d_r};
  assign ge    = (rs >= {1'b0, d_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wss_pkg::AR_IDLE: begin
        if (cmd.start) begin
          state_nxt = (cmd.mode == wss_pkg::AMODE_MULDIV) ? wss_pkg::AR_MUL
                                                          : wss_pkg::AR_DIV;
        end
      end
      wss_pkg::AR_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = wss_pkg::AR_DIV;
        end
      end
      wss_pkg::AR_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = wss_pkg::AR_IDLE;
        end
      end
      default: state_nxt = wss_pkg::AR_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    num_nxt    = num_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    d_nxt      = d_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    case (state_r)
      wss_pkg::AR_IDLE: begin
        if (cmd.start) begin
          cnt_nxt    = '0;
          d_nxt      = op_d;
          rem_nxt    = '0;
          quo_nxt    = '0;
          mcand_nxt  = {{(wss_pkg::PROD_W-wss_pkg::STAKE_W){1'b0}},
                        op_a[wss_pkg::STAKE_W-1:0]};
          mplier_nxt = op_b;
          if (cmd.mode == wss_pkg::AMODE_MULDIV) begin
            num_nxt = '0;
          end else begin
            num_nxt = {{(wss_pkg::DIVIDEND_W-wss_pkg::PICK_W){1'b0}}, op_a};
          end
        end
      end
      wss_pkg::AR_MUL: begin
        if (mplier_r[0]) begin
          num_nxt = num_r + {{(wss_pkg::DIVIDEND_W-wss_pkg::PROD_W){1'b0}}, mcand_r};
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = (cnt_r == MUL_LAST) ? 7'd0 : cnt_r + 7'd1;
      end
      wss_pkg::AR_DIV: begin
        num_nxt = num_r << 1;
        rem_nxt = ge ? rdiff[wss_pkg::TOTAL_W-1:0] : rs[wss_pkg::TOTAL_W-1:0];
        quo_nxt = {quo_r[wss_pkg::REWARD_W-2:0], ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) begin
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wss_pkg::AR_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    d_r      <= d_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
  end

  assign resp.busy = (state_r != wss_pkg::AR_IDLE);
  assign resp.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule

// File: sim/tb_weighted_stake_selector_unit.sv
// Testbench for weighted_stake_selector_unit: directed and random transactions
// checked against a scoreboard that tracks the stake table. Depends on wss_pkg and weighted_stake_selector_unit.
`timescale 1ns / 1ps
module tb_weighted_stake_selector_unit;

  typedef struct {
    wss_pkg::status_t             status;
    logic [3:0]                   chosen;
    logic                         present;
    logic                         active;
    logic [wss_pkg::STAKE_W-1:0]  stake;
    logic [wss_pkg::REWARD_W-1:0] rewards;
  } stake_reply_t;

  class stake_scoreboard;
    logic [wss_pkg::STAKE_W-1:0]  stake_floor;
    logic                         present_mark [16];
    logic                         active_mark [16];
    logic [wss_pkg::STAKE_W-1:0]  stakes [16];
    logic [wss_pkg::REWARD_W-1:0] rewards [16];
    stake_reply_t                 pending [$];
    int                           errors;
    int                           checked;

    function new();
      stake_floor = wss_pkg::STAKE_FLOOR_RST;
      errors = 0;
      checked = 0;
      for (int i = 0; i < 16; i++) begin
        present_mark[i] = 0;
        active_mark[i] = 0;
        stakes[i] = '0;
        rewards[i] = '0;
      end
    endfunction

    function logic [63:0] total_stake();
      logic [63:0] t;
      t = '0;
      for (int i = 0; i < 16; i++)
        if (active_mark[i]) t += stakes[i];
      return t;
    endfunction

    function void note_input(logic [2:0] op, logic [3:0] slot,
                             logic [wss_pkg::STAKE_W-1:0] amount, logic [63:0] pick);
      stake_reply_t r;
      logic [63:0]  tot;
      logic [63:0]  cum;
      logic [127:0] share;
      logic [64:0]  sum;
      r = '{wss_pkg::ST_OK, 4'd0, 1'b0, 1'b0, '0, '0};
      case (op)
        wss_pkg::OP_ADD: begin
          if (amount < stake_floor) r.status = wss_pkg::ST_LOW_STAKE;
          else begin
            present_mark[slot] = 1;
            active_mark[slot] = 1;
            stakes[slot] = amount;
            rewards[slot] = '0;
          end
        end
        wss_pkg::OP_REMOVE: begin
          if (!present_mark[slot]) r.status = wss_pkg::ST_ABSENT;
          else active_mark[slot] = 0;
        end
        wss_pkg::OP_SELECT: begin
          tot = total_stake();
          if (tot == 0) r.status = wss_pkg::ST_NO_STAKE;
          else begin
            pick = pick % tot;
            cum = '0;
            for (int i = 0; i < 16; i++) begin
              if (active_mark[i]) begin
                cum += stakes[i];
                if (pick < cum) begin
                  r.chosen = i[3:0];
                  break;
                end
              end
            end
          end
        end
        wss_pkg::OP_VALIDATE: if (!active_mark[slot]) r.status = wss_pkg::ST_ABSENT;
        wss_pkg::OP_DIST: begin
          tot = total_stake();
          if (tot == 0) r.status = wss_pkg::ST_NO_STAKE;
          else begin
            for (int i = 0; i < 16; i++) begin
              if (active_mark[i]) begin
                share = (128'(amount) * 128'(stakes[i])) / 128'(tot);
                sum = 65'(rewards[i]) + 65'(share[63:0]);
                rewards[i] = sum[64] ? '1 : sum[63:0];
              end
            end
          end
        end
        wss_pkg::OP_READ: begin
          if (!present_mark[slot]) r.status = wss_pkg::ST_ABSENT;
          else begin
            r.present = 1;
            r.active = active_mark[slot];
            r.stake = stakes[slot];
            r.rewards = rewards[slot];
          end
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(logic [1:0] status, logic [wss_pkg::OUT_TDATA_W-1:0] d);
      stake_reply_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d data %h", $time, status, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (status !== e.status || d[3:0] !== e.chosen || d[4] !== e.present ||
          d[5] !== e.active || d[61:6] !== e.stake || d[125:62] !== e.rewards ||
          d[127:126] !== 2'b00) begin
        $display("%0t: mismatch exp st %0d slot %0d p %0d a %0d stake %0d rew %0d", $time,
                 e.status, e.chosen, e.present, e.active, e.stake, e.rewards);
        $display("%0t:          act st %0d slot %0d p %0d a %0d stake %0d rew %0d", $time,
                 status, d[3:0], d[4], d[5], d[61:6], d[125:62]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [2:0] in_tuser;                       // opcode
  logic [wss_pkg::IN_TDATA_W-1:0] in_tdata;   // slot, amount, pick, zero pad
  logic out_tvalid, out_tready;
  logic [1:0] out_tuser;                      // status
  logic [wss_pkg::OUT_TDATA_W-1:0] out_tdata; // chosen_slot, present, active, stake,
                                              // rewards, pad
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [wss_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [wss_pkg::CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  stake_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int sent = 0;

  localparam logic [wss_pkg::STAKE_W-1:0] STAKE_MAX = '1;

  weighted_stake_selector_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else if (in_tvalid || sb.pending.size() != 0)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 50000) begin
      $display("FAIL weighted_stake_selector_unit");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] op, logic [3:0] slot,
                           logic [wss_pkg::STAKE_W-1:0] amount, logic [63:0] pick);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'b0, pick, amount, slot};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, slot, amount, pick);
    sent++;
  endtask

  task automatic write_stake_floor(logic [wss_pkg::STAKE_W-1:0] value);
    in_tvalid <= 0;
    wait (sb.pending.size() == 0);
    repeat (20) @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= wss_pkg::ADDR_STAKE_FLOOR;
    cfg_pwdata <= 64'(value);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.stake_floor = value;
    @(posedge clk);
  endtask

  function automatic logic [wss_pkg::STAKE_W-1:0] rand_stake();
    return wss_pkg::STAKE_W'({$urandom, $urandom});
  endfunction

  task automatic random_item();
    int w;
    logic [wss_pkg::STAKE_W-1:0] amt;
    logic [63:0] span;
    w = $urandom_range(99);
    amt = rand_stake();
    if (w < 30) begin
      case ($urandom_range(9))
        0: amt = sb.stake_floor - 1;
        1: amt = sb.stake_floor;
        2: amt = STAKE_MAX;
        3: amt = amt >> $urandom_range(55);
        default: begin
          span = 64'(STAKE_MAX - sb.stake_floor) + 1;
          amt = sb.stake_floor + wss_pkg::STAKE_W'({$urandom, $urandom} % span);
        end
      endcase
      send_item(wss_pkg::OP_ADD, 4'($urandom), amt, '0);
    end
    else if (w < 42) send_item(wss_pkg::OP_REMOVE, 4'($urandom), amt, {$urandom, $urandom});
    else if (w < 57) begin
      case ($urandom_range(5))
        0: send_item(wss_pkg::OP_SELECT, 4'($urandom), amt, '0);
        1: send_item(wss_pkg::OP_SELECT, 4'($urandom), amt, '1);
        default: send_item(wss_pkg::OP_SELECT, 4'($urandom), amt, {$urandom, $urandom});
      endcase
    end
    else if (w < 67) send_item(wss_pkg::OP_VALIDATE, 4'($urandom), amt, {$urandom, $urandom});
    else if (w < 72) send_item(wss_pkg::OP_DIST, 4'($urandom),
                               ($urandom_range(3) == 0) ? STAKE_MAX : amt,
                               {$urandom, $urandom});
    else if (w < 95) send_item(wss_pkg::OP_READ, 4'($urandom), amt, {$urandom, $urandom});
    else send_item(3'($urandom_range(6, 7)), 4'($urandom), amt, {$urandom, $urandom});
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty table, extremes, every opcode
    send_item(wss_pkg::OP_SELECT, 4'd0, '0, '1);
    send_item(wss_pkg::OP_DIST, 4'd0, STAKE_MAX, '0);
    send_item(wss_pkg::OP_READ, 4'd3, '0, '0);
    send_item(wss_pkg::OP_REMOVE, 4'd3, '0, '0);
    send_item(wss_pkg::OP_VALIDATE, 4'd3, '0, '0);
    send_item(wss_pkg::OP_ADD, 4'd0, wss_pkg::STAKE_FLOOR_RST - 1, '0);
    send_item(wss_pkg::OP_ADD, 4'd0, wss_pkg::STAKE_FLOOR_RST, '0);
    send_item(wss_pkg::OP_ADD, 4'd15, STAKE_MAX, '0);
    send_item(wss_pkg::OP_VALIDATE, 4'd15, '0, '0);
    send_item(wss_pkg::OP_SELECT, 4'd0, '0, '0);
    send_item(wss_pkg::OP_SELECT, 4'd0, '0, '1);
    send_item(wss_pkg::OP_DIST, 4'd0, STAKE_MAX, '0);
    send_item(wss_pkg::OP_DIST, 4'd0, 56'd1, '0);
    send_item(wss_pkg::OP_READ, 4'd15, '0, '0);
    send_item(wss_pkg::OP_READ, 4'd0, '0, '0);
    send_item(wss_pkg::OP_REMOVE, 4'd0, '0, '0);
    send_item(wss_pkg::OP_REMOVE, 4'd0, '0, '0);
    send_item(wss_pkg::OP_READ, 4'd0, '0, '0);
    send_item(wss_pkg::OP_VALIDATE, 4'd0, '0, '0);
    send_item(3'd6, 4'd15, STAKE_MAX, '1);
    send_item(3'd7, 4'd0, '0, '0);
    send_item(wss_pkg::OP_ADD, 4'd15, wss_pkg::STAKE_FLOOR_RST, '0);
    send_item(wss_pkg::OP_READ, 4'd15, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_stake_floor('0);
        1: write_stake_floor(STAKE_MAX - ($urandom_range(1) ? 0 : 1000));
        2: write_stake_floor(rand_stake() >> $urandom_range(8, 40));
        default: write_stake_floor(wss_pkg::STAKE_FLOOR_RST);
      endcase
      send_idle_pct = (ph == 1 || ph == 3) ? 66 : (ph == 2 ? 0 : 0);
      recv_stall_pct = (ph == 2 || ph == 3) ? 66 : 0;
      if (ph == 3) begin
        send_idle_pct = 33;
        recv_stall_pct = 33;
      end
      for (int k = 0; k < 120; k++) random_item();
    end

    in_tvalid <= 0;
    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d transactions over four handshake phases and four stake floor settings;",
             sent);
    $display("checked %0d results, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS weighted_stake_selector_unit");
    else
      $display("FAIL weighted_stake_selector_unit");
    $finish;
  end
endmodule

// File: filelist.f
hdl/wss_pkg.sv
hdl/wss_ram.sv
hdl/wss_arith.sv
hdl/weighted_stake_selector_unit.sv
sim/tb_weighted_stake_selector_unit.sv
